>>> design/bcru_pkg.sv
// Package with the word types, operation codes and constants of the branch unit.
`timescale 1ns / 1ps
package bcru_pkg;

  localparam int INSTR_BYTES = 4;
  localparam logic [31:0] ALIGN_MASK = ~32'h3;

  localparam int BO_SKIP_COND = 4;
  localparam int BO_COND_VALUE = 3;
  localparam int BO_SKIP_CTR = 2;
  localparam int BO_CTR_ZERO = 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    OP_B       = 4'd0,
    OP_BC      = 4'd1,
    OP_BCLR    = 4'd2,
    OP_BCCTR   = 4'd3,
    OP_CRAND   = 4'd4,
    OP_CRANDC  = 4'd5,
    OP_CREQV   = 4'd6,
    OP_CRNAND  = 4'd7,
    OP_CRNOR   = 4'd8,
    OP_CROR    = 4'd9,
    OP_CRORC   = 4'd10,
    OP_CRXOR   = 4'd11,
    OP_LOAD_CTR = 4'd12,
    OP_LOAD_LR = 4'd13,
    OP_LOAD_CR = 4'd14
  } op_t;

  typedef enum logic [2:0] {
    CL_BRANCH,
    CL_CRLOGIC,
    CL_LOAD_CTR,
    CL_LOAD_LR,
    CL_LOAD_CR,
    CL_NOP
  } class_t;

  typedef enum logic [2:0] {
    CR_AND, CR_ANDC, CR_EQV, CR_NAND, CR_NOR, CR_OR, CR_ORC, CR_XOR
  } cr_fn_t;

  typedef enum logic [1:0] {
    TGT_IMM,
    TGT_LR,
    TGT_CTR
  } target_sel_t;

  typedef struct packed {
    logic [3:0]         operation;
    logic [31:0]        current_address;
    logic signed [23:0] displacement;
    logic               absolute;
    logic               link;
    logic [4:0]         branch_options;
    logic [4:0]         condition_bit;
    logic [4:0]         source_bit_a;
    logic [4:0]         source_bit_b;
    logic [4:0]         dest_bit;
    logic [63:0]        write_value;
  } cmd_word_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] next_address;
    logic [31:0] link_value;
    logic [63:0] counter_value;
    logic [31:0] condition_value;
  } res_word_t;

  typedef struct packed {
    class_t      kind;
    cr_fn_t      cr_fn;
    target_sel_t target_sel;
    logic        ctr_use;
    logic        ctr_zero;
    logic        cond_use;
    logic        cond_want;
    logic        link;
    logic [4:0]  cond_bit;
    logic [4:0]  bit_a;
    logic [4:0]  bit_b;
    logic [4:0]  bit_d;
    logic [31:0] imm_target;
    logic [32:0] seq_address;
    logic [63:0] write_value;
  } entry_t;

endpackage

>>> design/branch_and_condition_register_unit_top.sv
// Top level of the branch and condition-register unit.
`timescale 1ns / 1ps
// The unit executes one branch, condition-register logical or register-load command
// word per clock cycle while no result stalls, and returns one result word for each.
// A command is classified by the front end and written into a two-word queue; the
// execute stage takes one word per cycle, updates CR, CTR and LR in that same cycle
// and registers the result, so a command passes a queue slot and then the result
// register. The sustained rate of one word per cycle is set by the execute stage,
// where each word reads the state left by the word before it. A stalled result holds
// the execute stage, and the queue then fills and stalls the command side.
module branch_and_condition_register_unit_top
  import bcru_pkg::*;
#(
  parameter int ADDRESS_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_word_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_word_t res
);

  entry_t front_entry;
  entry_t head_entry;
  logic   queue_not_empty;
  logic   queue_full;
  logic   pop;

  assign cmd_stall = queue_full;

  bcru_front u_front (
    .cmd   (cmd),
    .entry (front_entry)
  );

  bcru_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid && !queue_full),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head_entry),
    .not_empty  (queue_not_empty),
    .full       (queue_full)
  );

  bcru_exec #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .entry       (head_entry),
    .entry_valid (queue_not_empty),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res)
  );

endmodule

>>> design/bcru_front.sv
// Front end: classifies each command word and computes the addresses that need no state.
`timescale 1ns / 1ps
module bcru_front
  import bcru_pkg::*;
(
  input  cmd_word_t cmd,
  output entry_t    entry
);

  logic [31:0] offset;
  logic [31:0] rel_target;
  logic [32:0] seq_sum;

  always_comb begin
    if (cmd.operation == OP_B) begin
      offset = {{6{cmd.displacement[23]}}, cmd.displacement, 2'b00};
    end else begin
      offset = {{16{cmd.displacement[13]}}, cmd.displacement[13:0], 2'b00};
    end
    rel_target = cmd.absolute ? offset : cmd.current_address + offset;
    seq_sum = {1'b0, cmd.current_address} + 33'(INSTR_BYTES);
  end

  always_comb begin
    entry.kind = CL_NOP;
    entry.cr_fn = cr_fn_t'(3'(cmd.operation - OP_CRAND));
    entry.target_sel = TGT_IMM;
    entry.ctr_use = !cmd.branch_options[BO_SKIP_CTR];
    entry.ctr_zero = cmd.branch_options[BO_CTR_ZERO];
    entry.cond_use = !cmd.branch_options[BO_SKIP_COND];
    entry.cond_want = cmd.branch_options[BO_COND_VALUE];
    entry.link = cmd.link;
    entry.cond_bit = cmd.condition_bit;
    entry.bit_a = cmd.source_bit_a;
    entry.bit_b = cmd.source_bit_b;
    entry.bit_d = cmd.dest_bit;
    entry.imm_target = rel_target & ALIGN_MASK;
    entry.seq_address = seq_sum & {1'b1, ALIGN_MASK};
    entry.write_value = cmd.write_value;
    unique case (cmd.operation) inside
      OP_B: begin
        entry.kind = CL_BRANCH;
        entry.ctr_use = 1'b0;
        entry.cond_use = 1'b0;
      end
      OP_BC: begin
        entry.kind = CL_BRANCH;
      end
      OP_BCLR: begin
        entry.kind = CL_BRANCH;
        entry.target_sel = TGT_LR;
      end
      OP_BCCTR: begin
        entry.kind = CL_BRANCH;
        entry.target_sel = TGT_CTR;
        entry.ctr_use = 1'b0;
      end
      OP_CRAND, OP_CRANDC, OP_CREQV, OP_CRNAND, OP_CRNOR, OP_CROR, OP_CRORC, OP_CRXOR: begin
        entry.kind = CL_CRLOGIC;
      end
      OP_LOAD_CTR: entry.kind = CL_LOAD_CTR;
      OP_LOAD_LR:  entry.kind = CL_LOAD_LR;
      OP_LOAD_CR:  entry.kind = CL_LOAD_CR;
      default:     entry.kind = CL_NOP;
    endcase
  end

endmodule

>>> design/bcru_queue.sv
// Two-entry queue that decouples the front end from the execute stage.
`timescale 1ns / 1ps
module bcru_queue
  import bcru_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   not_empty,
  output logic   full
);

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign head = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("Queue popped while empty.");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("Queue count did not drop after a pop.");
`endif

endmodule

>>> design/bcru_exec.sv
// Execute stage: holds CR, CTR and LR, resolves branches and drives the result register.
`timescale 1ns / 1ps
module bcru_exec
  import bcru_pkg::*;
#(
  parameter int ADDRESS_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  entry_t    entry,
  input  logic      entry_valid,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output res_word_t res
);

  logic [31:0]              condition_reg;
  logic [63:0]              count_reg;
  logic [ADDRESS_WIDTH-1:0] link_reg;

  logic [31:0]              condition_reg_next;
  logic [63:0]              count_reg_next;
  logic [ADDRESS_WIDTH-1:0] link_reg_next;

  logic [63:0] ctr_dec;
  logic        ctr_ok;
  logic        cond_ok;
  logic        taken;
  logic [31:0] target;
  logic        bit_a;
  logic        bit_b;
  logic        cr_result;
  res_word_t   res_next;

  assign pop = entry_valid && (!res_valid || !res_stall);

  always_comb begin
    ctr_dec = count_reg - 64'd1;
    bit_a = condition_reg[5'd31 - entry.bit_a];
    bit_b = condition_reg[5'd31 - entry.bit_b];
    ctr_ok = !entry.ctr_use || (entry.ctr_zero ? (ctr_dec == '0) : (ctr_dec != '0));
    cond_ok = !entry.cond_use ||
              (condition_reg[5'd31 - entry.cond_bit] == entry.cond_want);
    case (entry.target_sel)
      TGT_LR:  target = link_reg[31:0] & ALIGN_MASK;
      TGT_CTR: target = count_reg[31:0] & ALIGN_MASK;
      default: target = entry.imm_target;
    endcase
    case (entry.cr_fn)
      CR_AND:  cr_result = bit_a & bit_b;
      CR_ANDC: cr_result = bit_a & ~bit_b;
      CR_EQV:  cr_result = ~(bit_a ^ bit_b);
      CR_NAND: cr_result = ~(bit_a & bit_b);
      CR_NOR:  cr_result = ~(bit_a | bit_b);
      CR_OR:   cr_result = bit_a | bit_b;
      CR_ORC:  cr_result = bit_a | ~bit_b;
      default: cr_result = bit_a ^ bit_b;
    endcase

    condition_reg_next = condition_reg;
    count_reg_next = count_reg;
    link_reg_next = link_reg;
    taken = 1'b0;
    unique case (entry.kind)
      CL_BRANCH: begin
        taken = ctr_ok && cond_ok;
        if (entry.ctr_use) begin
          count_reg_next = ctr_dec;
        end
        if (entry.link) begin
          link_reg_next = ADDRESS_WIDTH'(entry.seq_address);
        end
      end
      CL_CRLOGIC:  condition_reg_next[5'd31 - entry.bit_d] = cr_result;
      CL_LOAD_CTR: count_reg_next = entry.write_value;
      CL_LOAD_LR:  link_reg_next = entry.write_value[ADDRESS_WIDTH-1:0];
      CL_LOAD_CR:  condition_reg_next = entry.write_value[31:0];
      default: begin
      end
    endcase

    res_next.taken = taken;
    res_next.next_address = taken ? target : entry.seq_address[31:0];
    res_next.link_value = link_reg_next[31:0];
    res_next.counter_value = count_reg_next;
    res_next.condition_value = condition_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      condition_reg <= '0;
      count_reg <= '0;
      link_reg <= '0;
      res_valid <= 1'b0;
    end else if (pop) begin
      condition_reg <= condition_reg_next;
      count_reg <= count_reg_next;
      link_reg <= link_reg_next;
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_only_branch_taken: assert property (@(posedge clk) disable iff (rst)
    pop && entry.kind != CL_BRANCH |=> !res.taken)
    else $error("A non-branch word was reported as taken.");

  a_load_ctr: assert property (@(posedge clk) disable iff (rst)
    pop && entry.kind == CL_LOAD_CTR |=> count_reg == $past(entry.write_value))
    else $error("CTR load did not take the written value.");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !pop |=> $stable(condition_reg) && $stable(count_reg) && $stable(link_reg))
    else $error("Architected state changed without an executed word.");
`endif

endmodule

>>> test/tb.sv
// Self-checking testbench for the branch and condition-register unit.
`timescale 1ns / 1ps
module tb
  import bcru_pkg::*;
();

  localparam logic [3:0] OP_UNUSED = 4'hF;
  localparam int RANDOM_WORDS = 750;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  class bcru_result_tracker;
    logic [31:0] cr_bits;
    logic [63:0] ctr;
    logic [31:0] lr;
    res_word_t expected_results[$];
    int errors;

    function new();
      cr_bits = '0;
      ctr = '0;
      lr = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_command(cmd_word_t c);
      res_word_t e;
      logic [31:0] seq;
      logic [31:0] tgt;
      logic [31:0] off;
      logic ctr_ok;
      logic cond_ok;
      logic bit_a;
      logic bit_b;
      logic bit_r;
      seq = (c.current_address + 32'(INSTR_BYTES)) & ALIGN_MASK;
      tgt = seq;
      ctr_ok = 1'b1;
      cond_ok = 1'b1;
      e.taken = 1'b0;
      if (c.operation <= OP_BCCTR) begin
        case (c.operation)
          OP_B: begin
            off = {{6{c.displacement[23]}}, c.displacement, 2'b00};
            tgt = c.absolute ? off : c.current_address + off;
          end
          OP_BC: begin
            off = {{16{c.displacement[13]}}, c.displacement[13:0], 2'b00};
            tgt = c.absolute ? off : c.current_address + off;
          end
          OP_BCLR: tgt = lr;
          default: tgt = ctr[31:0];
        endcase
        tgt = tgt & ALIGN_MASK;
        if (c.operation != OP_B) begin
          if (c.operation != OP_BCCTR && !c.branch_options[BO_SKIP_CTR]) begin
            ctr = ctr - 64'd1;
            ctr_ok = c.branch_options[BO_CTR_ZERO] ? (ctr == 64'd0) : (ctr != 64'd0);
          end
          if (!c.branch_options[BO_SKIP_COND])
            cond_ok = cr_bits[5'd31 - c.condition_bit] == c.branch_options[BO_COND_VALUE];
        end
        e.taken = ctr_ok && cond_ok;
        if (c.link) lr = seq;
      end else if (c.operation <= OP_CRXOR) begin
        bit_a = cr_bits[5'd31 - c.source_bit_a];
        bit_b = cr_bits[5'd31 - c.source_bit_b];
        case (c.operation)
          OP_CRAND: bit_r = bit_a & bit_b;
          OP_CRANDC: bit_r = bit_a & ~bit_b;
          OP_CREQV: bit_r = ~(bit_a ^ bit_b);
          OP_CRNAND: bit_r = ~(bit_a & bit_b);
          OP_CRNOR: bit_r = ~(bit_a | bit_b);
          OP_CROR: bit_r = bit_a | bit_b;
          OP_CRORC: bit_r = bit_a | ~bit_b;
          default: bit_r = bit_a ^ bit_b;
        endcase
        cr_bits[5'd31 - c.dest_bit] = bit_r;
      end else if (c.operation == OP_LOAD_CTR) begin
        ctr = c.write_value;
      end else if (c.operation == OP_LOAD_LR) begin
        lr = c.write_value[31:0];
      end else if (c.operation == OP_LOAD_CR) begin
        cr_bits = c.write_value[31:0];
      end
      e.next_address = e.taken ? tgt : seq;
      e.link_value = lr;
      e.counter_value = ctr;
      e.condition_value = cr_bits;
      expected_results.push_back(e);
    endfunction

    function void check_result(res_word_t r);
      res_word_t e;
      if (expected_results.size() == 0) begin
        $error("result word %h arrived with no command outstanding", r);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (r.taken !== e.taken) begin
        $error("taken: expected %0h, got %0h", e.taken, r.taken);
        errors++;
      end
      if (r.next_address !== e.next_address) begin
        $error("next_address: expected %h, got %h", e.next_address, r.next_address);
        errors++;
      end
      if (r.link_value !== e.link_value) begin
        $error("link_value: expected %h, got %h", e.link_value, r.link_value);
        errors++;
      end
      if (r.counter_value !== e.counter_value) begin
        $error("counter_value: expected %h, got %h", e.counter_value, r.counter_value);
        errors++;
      end
      if (r.condition_value !== e.condition_value) begin
        $error("condition_value: expected %h, got %h", e.condition_value, r.condition_value);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_word_t cmd;
  logic res_valid;
  logic res_stall;
  res_word_t res;

  logic hold_req;
  int sent_words;
  int no_gap_left;
  int cycles;
  bcru_result_tracker tracker = new();

  branch_and_condition_register_unit_top #(.ADDRESS_WIDTH(32)) u_top (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) tracker.note_command(cmd);
      if (res_valid && !res_stall) tracker.check_result(res);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("branch_and_condition_register_unit_top test failed");
      $finish;
    end
  end

  function automatic cmd_word_t noise_cmd();
    cmd_word_t c;
    c.operation = 4'($urandom);
    c.current_address = $urandom;
    c.displacement = 24'($urandom);
    c.absolute = 1'($urandom);
    c.link = 1'($urandom);
    c.branch_options = 5'($urandom);
    c.condition_bit = 5'($urandom);
    c.source_bit_a = 5'($urandom);
    c.source_bit_b = 5'($urandom);
    c.dest_bit = 5'($urandom);
    c.write_value = {$urandom, $urandom};
    return c;
  endfunction

  function automatic cmd_word_t branch_cmd(logic [3:0] op, logic [31:0] addr,
                                           logic [23:0] disp, logic aa, logic lk,
                                           logic [4:0] bo, logic [4:0] bi);
    cmd_word_t c;
    c = noise_cmd();
    c.operation = op;
    c.current_address = addr;
    c.displacement = disp;
    c.absolute = aa;
    c.link = lk;
    c.branch_options = bo;
    c.condition_bit = bi;
    return c;
  endfunction

  function automatic cmd_word_t reg_cmd(logic [3:0] op, logic [4:0] a, logic [4:0] b,
                                        logic [4:0] d, logic [63:0] wv);
    cmd_word_t c;
    c = noise_cmd();
    c.operation = op;
    c.source_bit_a = a;
    c.source_bit_b = b;
    c.dest_bit = d;
    c.write_value = wv;
    return c;
  endfunction

  function automatic cmd_word_t random_cmd();
    cmd_word_t c;
    int r;
    c = noise_cmd();
    r = $urandom_range(0, 99);
    if (r < 5) return c;
    if (r < 15) c.operation = OP_B;
    else if (r < 45) c.operation = OP_BC;
    else if (r < 57) c.operation = OP_BCLR;
    else if (r < 67) c.operation = OP_BCCTR;
    else if (r < 87) c.operation = 4'($urandom_range(int'(OP_CRAND), int'(OP_CRXOR)));
    else if (r < 97) c.operation = 4'($urandom_range(int'(OP_LOAD_CTR), int'(OP_LOAD_CR)));
    else c.operation = OP_UNUSED;
    if ($urandom_range(0, 9) != 0) c.current_address[1:0] = 2'b00;
    if (c.operation == OP_LOAD_CTR && $urandom_range(0, 1) == 1)
      c.write_value = 64'($urandom_range(0, 4));
    return c;
  endfunction

  task automatic send_word(input cmd_word_t w);
    cmd <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent_words++;
  endtask

  task automatic idle_after_word();
    int r;
    int n;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_gap_left = $urandom_range(20, 40);
      return;
    end
    if (r < 55) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 40);
    if (n > 0) begin
      cmd_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_and_idle(input cmd_word_t w);
    send_word(w);
    idle_after_word();
  endtask

  task automatic wait_all_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic counter_loop();
    cmd_word_t c;
    int n;
    n = $urandom_range(1, 5);
    send_and_idle(reg_cmd(OP_LOAD_CTR, 5'($urandom), 5'($urandom), 5'($urandom),
                          64'(n)));
    repeat (n + 1) begin
      c = random_cmd();
      c.operation = ($urandom_range(0, 2) == 0) ? OP_BCLR : OP_BC;
      c.branch_options[BO_SKIP_CTR] = 1'b0;
      send_and_idle(c);
    end
  endtask

  task automatic directed_phase();
    send_and_idle(reg_cmd(OP_LOAD_CR, 5'd0, 5'd0, 5'd0, 64'hFFFF_FFFF_A5A5_0F0F));
    send_and_idle(reg_cmd(OP_LOAD_CTR, 5'd0, 5'd0, 5'd0, 64'd1));
    send_and_idle(branch_cmd(OP_BC, 32'h0000_1000, 24'hFF_E000, 1'b0, 1'b1, 5'h10, 5'd0));
    send_and_idle(branch_cmd(OP_BC, 32'h0000_2000, 24'h00_1FFF, 1'b0, 1'b0, 5'h12, 5'd0));
    send_and_idle(reg_cmd(OP_LOAD_CTR, 5'd0, 5'd0, 5'd0, 64'd2));
    send_and_idle(branch_cmd(OP_BCLR, 32'h0000_3000, 24'h0, 1'b0, 1'b1, 5'h10, 5'd0));
    send_and_idle(reg_cmd(OP_LOAD_LR, 5'd0, 5'd0, 5'd0, 64'hDEAD_BEEF_FFFF_FFFF));
    send_and_idle(branch_cmd(OP_BCLR, 32'h0000_4000, 24'h0, 1'b0, 1'b0, 5'h14, 5'd0));
    send_and_idle(branch_cmd(OP_B, 32'hFFFF_FFFC, 24'h7F_FFFF, 1'b0, 1'b1, 5'h00, 5'd0));
    send_and_idle(branch_cmd(OP_B, 32'h0000_0100, 24'h80_0000, 1'b1, 1'b0, 5'h1F, 5'd31));
    send_and_idle(branch_cmd(OP_BC, 32'h0000_0004, 24'h00_2000, 1'b1, 1'b0, 5'h14, 5'd0));
    send_and_idle(reg_cmd(OP_LOAD_CTR, 5'd0, 5'd0, 5'd0, 64'hFFFF_FFFF_8765_4321));
    send_and_idle(branch_cmd(OP_BCCTR, 32'h0000_5000, 24'h0, 1'b0, 1'b1, 5'h00, 5'd0));
    send_and_idle(branch_cmd(OP_BCCTR, 32'h0000_6000, 24'h0, 1'b0, 1'b0, 5'h08, 5'd0));
    send_and_idle(branch_cmd(OP_BCCTR, 32'h0000_7000, 24'h0, 1'b0, 1'b0, 5'h0D, 5'd31));
    send_and_idle(branch_cmd(OP_BC, 32'h0000_8000, 24'h00_0010, 1'b0, 1'b0, 5'h1F, 5'd31));
    send_and_idle(reg_cmd(OP_CRAND, 5'd0, 5'd1, 5'd2, 64'd0));
    send_and_idle(reg_cmd(OP_CRANDC, 5'd31, 5'd30, 5'd29, 64'd0));
    send_and_idle(reg_cmd(OP_CREQV, 5'd16, 5'd8, 5'd0, 64'd0));
    send_and_idle(reg_cmd(OP_CRNAND, 5'd1, 5'd0, 5'd31, 64'd0));
    send_and_idle(reg_cmd(OP_CRNOR, 5'd4, 5'd5, 5'd4, 64'd0));
    send_and_idle(reg_cmd(OP_CROR, 5'd7, 5'd7, 5'd8, 64'd0));
    send_and_idle(reg_cmd(OP_CRORC, 5'd10, 5'd20, 5'd30, 64'd0));
    send_and_idle(reg_cmd(OP_CRXOR, 5'd3, 5'd12, 5'd24, 64'd0));
    send_and_idle(reg_cmd(OP_UNUSED, 5'd0, 5'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF));
  endtask

  initial begin
    res_stall <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      int r;
      int len;
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          res_stall <= 1'b0;
          len = $urandom_range(1, 8);
        end else if (r < 90) begin
          res_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 97) begin
          res_stall <= 1'b1;
          len = $urandom_range(4, 20);
        end else begin
          res_stall <= 1'b0;
          len = $urandom_range(30, 60);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    logic held;
    logic paused;
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;
    hold_req = 1'b0;
    sent_words = 0;
    no_gap_left = 0;
    cycles = 0;
    held = 1'b0;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_phase();
    wait_all_results();
    sent_words = 0;
    while (sent_words < RANDOM_WORDS) begin
      if (!held && sent_words >= RANDOM_WORDS / 3) begin
        held = 1'b1;
        hold_req = 1'b1;
        repeat (24) send_word(random_cmd());
      end else if (!paused && sent_words >= 2 * RANDOM_WORDS / 3) begin
        paused = 1'b1;
        wait_all_results();
      end else if ($urandom_range(0, 99) < 15) begin
        counter_loop();
      end else begin
        send_and_idle(random_cmd());
      end
    end
    wait_all_results();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("branch_and_condition_register_unit_top test passed");
    else
      $display("branch_and_condition_register_unit_top test failed");
    $finish;
  end

endmodule
